// ===== sv/mfdf_pkg.sv =====
// Shared types and constants of the mesh flood duplicate filter.
// Used by the channel interfaces, the cache unit and the top level.
package mfdf_pkg;

    localparam int CACHE_DEPTH  = 8;
    localparam int HEADER_BYTES = 5;
    localparam int PTR_W        = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_HEADER = 2'd1;
    localparam logic [1:0] ACT_ORIG   = 2'd2;

    localparam logic [1:0] DROP_NONE  = 2'd0;
    localparam logic [1:0] DROP_SHORT = 2'd1;
    localparam logic [1:0] DROP_HOPS  = 2'd2;
    localparam logic [1:0] DROP_DUP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MY_NODE_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MY_CLUSTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHONE_ID     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ID = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOPS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE      = 3'd7;

    localparam logic [15:0] NO_LINK     = 16'hFFFF;
    localparam logic [31:0] MAX_AGE_RST = 32'd10000;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] conn_handle;
        logic [7:0]  packet_length;
        logic [7:0]  dst_id;
        logic [7:0]  src_id;
        logic [7:0]  seq_num;
        logic [7:0]  hops_left;
    } t_in_item;

    typedef struct packed {
        logic        execute;
        logic        forward;
        logic [7:0]  out_src;
        logic [7:0]  out_seq;
        logic [7:0]  out_hops;
        logic [1:0]  drop_reason;
        logic [15:0] phone_link;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic        start;
        logic        insert;
        logic [7:0]  src;
        logic [7:0]  seq;
        logic [31:0] tick;
        logic [31:0] max_age;
    } t_cache_req;

    typedef struct packed {
        logic done;
        logic dup;
    } t_cache_resp;

endpackage

// ===== sv/mfdf_in_if.sv =====
// Input item channel: valid, ready and one header or command item.
// Depends on mfdf_pkg.
interface mfdf_in_if;
    logic                valid;
    logic                ready;
    mfdf_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mfdf_out_if.sv =====
// Result item channel: valid, ready and one filter decision.
// Depends on mfdf_pkg.
interface mfdf_out_if;
    logic                valid;
    logic                ready;
    mfdf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mfdf_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and data.
// Depends on mfdf_pkg.
interface mfdf_cfg_if;
    logic                valid;
    logic                ready;
    mfdf_pkg::t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mfdf_cache.sv =====
// Ring cache of source and sequence pairs with time stamps, walked one
// entry a cycle through a single match and age comparator.
// Depends on mfdf_pkg.
module mfdf_cache (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mfdf_pkg::t_cache_req   i_req,
    output mfdf_pkg::t_cache_resp  o_resp
);

    logic [7:0]                 r_src   [mfdf_pkg::CACHE_DEPTH];
    logic [7:0]                 r_seq   [mfdf_pkg::CACHE_DEPTH];
    logic [31:0]                r_stamp [mfdf_pkg::CACHE_DEPTH];
    logic [mfdf_pkg::PTR_W-1:0] r_ptr;
    logic [mfdf_pkg::PTR_W-1:0] r_idx;
    logic                       r_walk;
    logic [7:0]                 r_key_src;
    logic [7:0]                 r_key_seq;

    logic        hit;
    logic        fresh;
    logic        last;
    logic [31:0] age;

    always_comb begin
        hit   = (r_src[r_idx] == r_key_src) && (r_seq[r_idx] == r_key_seq);
        age   = i_req.tick - r_stamp[r_idx];
        fresh = age < i_req.max_age;
        last  = r_idx == mfdf_pkg::PTR_W'(mfdf_pkg::CACHE_DEPTH - 1);
    end

    assign o_resp.done = r_walk && (hit || last);
    assign o_resp.dup  = r_walk && hit && fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mfdf_pkg::CACHE_DEPTH; k++) begin
                r_src[k]   <= '0;
                r_seq[k]   <= '0;
                r_stamp[k] <= '0;
            end
            r_ptr  <= '0;
            r_idx  <= '0;
            r_walk <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_walk    <= 1'b1;
                r_idx     <= '0;
                r_key_src <= i_req.src;
                r_key_seq <= i_req.seq;
            end else if (r_walk) begin
                if (hit || last) begin
                    r_walk <= 1'b0;
                end else begin
                    r_idx <= r_idx + mfdf_pkg::PTR_W'(1);
                end
                // invalidate a stale first match
                if (hit && !fresh) begin
                    r_src[r_idx] <= '0;
                end
            end
            if (i_req.insert) begin
                r_src[r_ptr]   <= i_req.src;
                r_seq[r_ptr]   <= i_req.seq;
                r_stamp[r_ptr] <= i_req.tick;
                if (r_ptr == mfdf_pkg::PTR_W'(mfdf_pkg::CACHE_DEPTH - 1)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + mfdf_pkg::PTR_W'(1);
                end
            end
        end
    end

endmodule

// ===== sv/mesh_flood_duplicate_filter_unit.sv =====
// Top level of the mesh flood duplicate filter: sequencer, configuration
// registers, counters and result register. Depends on mfdf_pkg, the
// channel interfaces and mfdf_cache.
//
// A tick item is taken and gives no result. An originate item, a header
// dropped as too short or with zero hops, and a header from the phone are
// accepted, then finished. Any other header is accepted, then walks the
// cache one entry a cycle through the shared comparator, stopping at the
// first source and sequence match or at the last entry, then is finished.
// The input is not ready while an item is in work. The finish step waits
// while the result register still holds an untaken result, and no new item
// is accepted meanwhile.
module mesh_flood_duplicate_filter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfdf_in_if.sink      i_in,
    mfdf_cfg_if.sink     i_cfg,
    mfdf_out_if.source   o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  r_state, n_state;
    mfdf_pkg::t_in_item  r_item;
    logic        r_dup;
    logic [31:0] r_tick;
    logic [7:0]  r_next_seq;
    logic [15:0] r_phone_link;
    logic        r_out_valid;
    mfdf_pkg::t_out_item r_out;

    logic [7:0]  r_my_node_id;
    logic [7:0]  r_my_cluster;
    logic [7:0]  r_cluster_base;
    logic [7:0]  r_cluster_max;
    logic [7:0]  r_phone_id;
    logic [7:0]  r_broadcast_id;
    logic [7:0]  r_max_hops;
    logic [31:0] r_max_age;

    mfdf_pkg::t_cache_req  cache_req;
    mfdf_pkg::t_cache_resp cache_resp;
    mfdf_pkg::t_out_item   res;

    logic in_fire;
    logic done_fire;
    logic walk_start;
    logic is_orig;
    logic from_phone;
    logic hdr_ok;
    logic in_cluster;
    logic to_local;
    logic [7:0] hops_dec;
    logic [7:0] dst_off;

    assign i_in.ready  = r_state == ST_IDLE;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign done_fire   = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign walk_start = in_fire && (i_in.data.action == mfdf_pkg::ACT_HEADER)
        && (i_in.data.packet_length >= 8'(mfdf_pkg::HEADER_BYTES))
        && (i_in.data.hops_left != 8'd0)
        && (i_in.data.src_id != r_phone_id);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (walk_start) begin
                        n_state = ST_WALK;
                    end else if (i_in.data.action == mfdf_pkg::ACT_HEADER
                                 || i_in.data.action == mfdf_pkg::ACT_ORIG) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (cache_resp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (done_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        is_orig    = r_item.action == mfdf_pkg::ACT_ORIG;
        hdr_ok     = (r_item.packet_length >= 8'(mfdf_pkg::HEADER_BYTES))
                     && (r_item.hops_left != 8'd0);
        from_phone = r_item.src_id == r_phone_id;
        dst_off    = r_item.dst_id - r_cluster_base;
        in_cluster = (r_item.dst_id >= r_cluster_base) && (r_item.dst_id <= r_cluster_max)
                     && (dst_off == r_my_cluster);
        to_local   = (r_item.dst_id == r_my_node_id) || (r_item.dst_id == r_phone_id);
        hops_dec   = r_item.hops_left - 8'd1;

        res.execute     = 1'b0;
        res.forward     = 1'b0;
        res.out_src     = r_item.src_id;
        res.out_seq     = r_item.seq_num;
        res.out_hops    = r_item.hops_left;
        res.drop_reason = mfdf_pkg::DROP_NONE;
        res.phone_link  = r_phone_link;

        if (is_orig) begin
            res.forward  = 1'b1;
            res.out_src  = r_my_node_id;
            res.out_seq  = r_next_seq;
            res.out_hops = r_max_hops;
        end else if (r_item.packet_length < 8'(mfdf_pkg::HEADER_BYTES)) begin
            res.drop_reason = mfdf_pkg::DROP_SHORT;
        end else if (r_item.hops_left == 8'd0) begin
            res.drop_reason = mfdf_pkg::DROP_HOPS;
        end else if (!from_phone && r_dup) begin
            res.drop_reason = mfdf_pkg::DROP_DUP;
        end else begin
            if (from_phone) begin
                res.out_src    = r_my_node_id;
                res.out_seq    = r_next_seq;
                res.phone_link = r_item.conn_handle;
            end
            res.execute = to_local || (r_item.dst_id == r_broadcast_id) || in_cluster;
            if (!to_local) begin
                res.out_hops = hops_dec;
                res.forward  = hops_dec != 8'd0;
            end
        end
    end

    always_comb begin
        cache_req.start   = walk_start;
        cache_req.insert  = done_fire && (res.drop_reason == mfdf_pkg::DROP_NONE);
        cache_req.src     = (r_state == ST_DONE) ? res.out_src : i_in.data.src_id;
        cache_req.seq     = (r_state == ST_DONE) ? res.out_seq : i_in.data.seq_num;
        cache_req.tick    = r_tick;
        cache_req.max_age = r_max_age;
    end

    mfdf_cache u_cache (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (cache_req),
        .o_resp (cache_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_dup          <= 1'b0;
            r_tick         <= '0;
            r_next_seq     <= '0;
            r_phone_link   <= mfdf_pkg::NO_LINK;
            r_out_valid    <= 1'b0;
            r_my_node_id   <= 8'd0;
            r_my_cluster   <= 8'd0;
            r_cluster_base <= 8'd240;
            r_cluster_max  <= 8'd254;
            r_phone_id     <= 8'd0;
            r_broadcast_id <= 8'd255;
            r_max_hops     <= 8'd5;
            r_max_age      <= mfdf_pkg::MAX_AGE_RST;
        end else begin
            r_state <= n_state;

            if (in_fire) begin
                r_item <= i_in.data;
                r_dup  <= 1'b0;
                if (i_in.data.action == mfdf_pkg::ACT_TICK) begin
                    r_tick <= r_tick + 32'd1;
                end
            end

            if (r_state == ST_WALK && cache_resp.done) begin
                r_dup <= cache_resp.dup;
            end

            if (done_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
                r_phone_link <= res.phone_link;
                if (is_orig || (hdr_ok && from_phone)) begin
                    r_next_seq <= r_next_seq + 8'd1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    mfdf_pkg::REG_MY_NODE_ID:   r_my_node_id   <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_MY_CLUSTER:   r_my_cluster   <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_CLUSTER_BASE: r_cluster_base <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_CLUSTER_MAX:  r_cluster_max  <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_PHONE_ID:     r_phone_id     <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_BROADCAST_ID: r_broadcast_id <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_MAX_HOPS:     r_max_hops     <= i_cfg.data.value[7:0];
                    mfdf_pkg::REG_MAX_AGE:      r_max_age      <= i_cfg.data.value;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/mesh_flood_duplicate_filter_unit_tb.sv =====
// Testbench for the mesh flood duplicate filter: directed table, then random phases
// checked against an in-bench model of the filter and its cache.
// Depends on mfdf_pkg, the three channel interfaces and mesh_flood_duplicate_filter_unit.
module mesh_flood_duplicate_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfdf_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int NUM_DIR       = 22;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = CACHE_DEPTH + 8;
    localparam int HOLD_OFF      = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int POOL_SIZE     = 12;
    localparam t_out_item NO_WANT = '0;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    mfdf_in_if  in_ch();
    mfdf_out_if res_ch();
    mfdf_cfg_if cfg_ch();

    mesh_flood_duplicate_filter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // filter model state
    logic [7:0]  cf_node, cf_cluster, cf_base, cf_max, cf_phone, cf_bcast, cf_hops;
    logic [31:0] cf_age;
    logic [31:0] tick_q;
    logic [7:0]  next_seq_q;
    logic [7:0]  slot_src [CACHE_DEPTH];
    logic [7:0]  slot_seq [CACHE_DEPTH];
    logic [31:0] slot_stamp [CACHE_DEPTH];
    logic [PTR_W-1:0] slot_ptr;
    logic [15:0] link_q;

    t_out_item   decisions_due [$];
    logic [15:0] pair_pool [$];
    int          mismatch_count;
    bit          tx_no_idle;
    bit          rx_no_idle;
    bit          hold_off_req;
    t_dir_row    dir_rows [NUM_DIR];

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic void reset_model();
        cf_node    = 8'd0;
        cf_cluster = 8'd0;
        cf_base    = 8'd240;
        cf_max     = 8'd254;
        cf_phone   = 8'd0;
        cf_bcast   = 8'd255;
        cf_hops    = 8'd5;
        cf_age     = MAX_AGE_RST;
        tick_q     = '0;
        next_seq_q = '0;
        slot_ptr   = '0;
        link_q     = NO_LINK;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            slot_src[i]   = '0;
            slot_seq[i]   = '0;
            slot_stamp[i] = '0;
        end
    endfunction

    function automatic void remember_pair(input logic [7:0] src, input logic [7:0] seq);
        slot_src[slot_ptr]   = src;
        slot_seq[slot_ptr]   = seq;
        slot_stamp[slot_ptr] = tick_q;
        slot_ptr = (slot_ptr == PTR_W'(CACHE_DEPTH - 1)) ? '0 : slot_ptr + PTR_W'(1);
    endfunction

    // first match only: fresh means duplicate, stale gets invalidated
    function automatic bit seen_recently(input logic [7:0] src, input logic [7:0] seq);
        logic [31:0] age;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (slot_src[i] == src && slot_seq[i] == seq) begin
                age = tick_q - slot_stamp[i];
                if (age < cf_age) begin
                    return 1'b1;
                end
                slot_src[i] = '0;
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit filter_decide(input t_in_item it, output t_out_item d);
        logic [7:0] src, seq, hops, dst, offs;
        logic       exec, fwd, dup, in_cl;
        logic [1:0] drop;
        d    = '0;
        exec = 1'b0;
        fwd  = 1'b0;
        dup  = 1'b0;
        drop = DROP_NONE;
        src  = it.src_id;
        seq  = it.seq_num;
        hops = it.hops_left;
        dst  = it.dst_id;
        case (it.action)
            ACT_TICK: begin
                tick_q = tick_q + 32'd1;
                return 1'b0;
            end
            ACT_ORIG: begin
                src = cf_node;
                seq = next_seq_q;
                next_seq_q = next_seq_q + 8'd1;
                hops = cf_hops;
                remember_pair(src, seq);
                fwd = 1'b1;
            end
            ACT_HEADER: begin
                if (it.packet_length < 8'(HEADER_BYTES)) begin
                    drop = DROP_SHORT;
                end else if (hops == 8'd0) begin
                    drop = DROP_HOPS;
                end else begin
                    if (src == cf_phone) begin
                        link_q = it.conn_handle;
                        src = cf_node;
                        seq = next_seq_q;
                        next_seq_q = next_seq_q + 8'd1;
                    end else begin
                        dup = seen_recently(src, seq);
                    end
                    if (dup) begin
                        drop = DROP_DUP;
                    end else begin
                        offs  = dst - cf_base;
                        in_cl = (dst >= cf_base) && (dst <= cf_max) && (offs == cf_cluster);
                        remember_pair(src, seq);
                        exec = (dst == cf_node) || (dst == cf_bcast) || (dst == cf_phone) || in_cl;
                        if (dst != cf_node && dst != cf_phone) begin
                            hops = hops - 8'd1;
                            fwd  = (hops != 8'd0);
                        end
                    end
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        d.execute     = exec;
        d.forward     = fwd;
        d.out_src     = src;
        d.out_seq     = seq;
        d.out_hops    = hops;
        d.drop_reason = drop;
        d.phone_link  = link_q;
        return 1'b1;
    endfunction

    task automatic check_decision(input t_out_item want, input t_out_item got);
        if (got.execute !== want.execute) begin
            $error("execute: expected %0d, actual %0d", want.execute, got.execute);
            mismatch_count++;
        end
        if (got.forward !== want.forward) begin
            $error("forward: expected %0d, actual %0d", want.forward, got.forward);
            mismatch_count++;
        end
        if (got.out_src !== want.out_src) begin
            $error("out_src: expected %0d, actual %0d", want.out_src, got.out_src);
            mismatch_count++;
        end
        if (got.out_seq !== want.out_seq) begin
            $error("out_seq: expected %0d, actual %0d", want.out_seq, got.out_seq);
            mismatch_count++;
        end
        if (got.out_hops !== want.out_hops) begin
            $error("out_hops: expected %0d, actual %0d", want.out_hops, got.out_hops);
            mismatch_count++;
        end
        if (got.drop_reason !== want.drop_reason) begin
            $error("drop_reason: expected %0d, actual %0d", want.drop_reason,
                   got.drop_reason);
            mismatch_count++;
        end
        if (got.phone_link !== want.phone_link) begin
            $error("phone_link: expected %0h, actual %0h", want.phone_link, got.phone_link);
            mismatch_count++;
        end
    endtask

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item pick_item();
        t_in_item    it;
        int          r;
        logic [15:0] pr;
        it.conn_handle = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 24) begin
            it.action = ACT_TICK;
        end else if (r < 34) begin
            it.action = ACT_ORIG;
        end else if (r < 38) begin
            it.action = ACT_NONE;
        end else begin
            it.action = ACT_HEADER;
        end
        it.packet_length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, HEADER_BYTES - 1))
                                                       : 8'($urandom_range(HEADER_BYTES, 255));
        r = $urandom_range(0, 99);
        if (r < 8) begin
            it.hops_left = 8'd0;
        end else if (r < 30) begin
            it.hops_left = 8'($urandom_range(1, 2));
        end else begin
            it.hops_left = 8'($urandom_range(1, 255));
        end
        r = $urandom_range(0, 99);
        it.src_id  = 8'($urandom);
        it.seq_num = 8'($urandom);
        if (r < 25) begin
            it.src_id = cf_phone;
        end else if (r < 65 && pair_pool.size() > 0) begin
            pr = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
            it.src_id  = pr[15:8];
            it.seq_num = pr[7:0];
        end else if (r < 72) begin
            it.src_id  = 8'd0;
            it.seq_num = 8'd0;
        end
        case ($urandom_range(0, 6))
            0: it.dst_id = cf_node;
            1: it.dst_id = cf_phone;
            2: it.dst_id = cf_bcast;
            3: it.dst_id = cf_base + cf_cluster;
            4: it.dst_id = (cf_base <= cf_max) ? 8'($urandom_range(cf_base, cf_max))
                                                : 8'($urandom);
            default: it.dst_id = 8'($urandom);
        endcase
        return it;
    endfunction

    task automatic drive_item(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item d;
        gap = pick_gap(tx_no_idle);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (filter_decide(it, d)) begin
            decisions_due.push_back(typed ? want : d);
            if (d.drop_reason == DROP_NONE) begin
                pair_pool.push_back({d.out_src, d.out_seq});
                if (pair_pool.size() > POOL_SIZE) begin
                    void'(pair_pool.pop_front());
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_MY_NODE_ID:   cf_node    = val[7:0];
            REG_MY_CLUSTER:   cf_cluster = val[7:0];
            REG_CLUSTER_BASE: cf_base    = val[7:0];
            REG_CLUSTER_MAX:  cf_max     = val[7:0];
            REG_PHONE_ID:     cf_phone   = val[7:0];
            REG_BROADCAST_ID: cf_bcast   = val[7:0];
            REG_MAX_HOPS:     cf_hops    = val[7:0];
            REG_MAX_AGE:      cf_age     = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (decisions_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input int phase);
        logic [31:0] v [8];
        logic [7:0]  b;
        case (phase)
            0: v = '{32'd10, 32'd2, 32'd240, 32'd254, 32'd200, 32'd255, 32'd5, 32'd3};
            1: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1};
            2: v = '{32'd255, 32'd255, 32'd255, 32'd255, 32'd255, 32'd255, 32'd255,
                     32'hFFFF_FFFF};
            default: begin
                b = 8'($urandom_range(200, 250));
                v[0] = $urandom_range(0, 255);
                v[1] = $urandom_range(0, 15);
                v[2] = b;
                v[3] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(b, 255);
                v[4] = $urandom_range(0, 255);
                v[5] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 32'd255;
                v[6] = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                   : $urandom_range(1, 255);
                case ($urandom_range(0, 9))
                    0, 1: v[7] = $urandom_range(41, 5000);
                    2:    v[7] = ($urandom == 0) ? 32'd1 : $urandom;
                    default: v[7] = $urandom_range(1, 40);
                endcase
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            write_reg(CFG_IDX_W'(i), v[i]);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (res_ch.valid && res_ch.ready) begin
            if (decisions_due.size() == 0) begin
                $error("result with no decision pending: src %0d seq %0d",
                       res_ch.data.out_src, res_ch.data.out_seq);
                mismatch_count++;
            end else begin
                want = decisions_due.pop_front();
                check_decision(want, res_ch.data);
            end
        end
    end

    initial begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (!rx_no_idle && $urandom_range(0, 5) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                             : $urandom_range(1, 3);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int count;
        t_in_item it;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        mismatch_count = 0;
        tx_no_idle     = 1'b0;
        rx_no_idle     = 1'b0;
        hold_off_req   = 1'b0;
        reset_model();

        dir_rows = '{
            '{'{ACT_HEADER, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
              '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0, DROP_SHORT, NO_LINK}},
            '{'{ACT_HEADER, 16'hFFFF, 8'd4, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
              '{1'b0, 1'b0, 8'd255, 8'd255, 8'd255, DROP_SHORT, NO_LINK}},
            '{'{ACT_HEADER, 16'h0001, 8'd5, 8'd10, 8'd7, 8'd9, 8'd0}, 1'b1,
              '{1'b0, 1'b0, 8'd7, 8'd9, 8'd0, DROP_HOPS, NO_LINK}},
            '{'{ACT_HEADER, 16'h0002, 8'd5, 8'd1, 8'd0, 8'd0, 8'd3}, 1'b1,
              '{1'b0, 1'b0, 8'd0, 8'd0, 8'd3, DROP_DUP, NO_LINK}},
            '{'{ACT_ORIG, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
              '{1'b0, 1'b1, 8'd10, 8'd0, 8'd5, DROP_NONE, NO_LINK}},
            '{'{ACT_HEADER, 16'h1234, 8'd255, 8'd255, 8'd200, 8'd77, 8'd255}, 1'b1,
              '{1'b1, 1'b1, 8'd10, 8'd1, 8'd254, DROP_NONE, 16'h1234}},
            '{'{ACT_HEADER, 16'h0003, 8'd5, 8'd10, 8'd20, 8'd5, 8'd4}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0004, 8'd6, 8'd99, 8'd20, 8'd5, 8'd4}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0005, 8'd5, 8'd200, 8'd21, 8'd5, 8'd1}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0006, 8'd5, 8'd242, 8'd22, 8'd0, 8'd1}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0007, 8'd5, 8'd241, 8'd23, 8'd1, 8'd2}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0008, 8'd5, 8'd254, 8'd24, 8'd2, 8'd8}, 1'b0, NO_WANT},
            '{'{ACT_TICK, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_WANT},
            '{'{ACT_TICK, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, NO_WANT},
            '{'{ACT_TICK, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0009, 8'd5, 8'd100, 8'd20, 8'd5, 8'd4}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h000A, 8'd5, 8'd100, 8'd20, 8'd5, 8'd4}, 1'b0, NO_WANT},
            '{'{ACT_NONE, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, NO_WANT},
            '{'{ACT_ORIG, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h000B, 8'd5, 8'd5, 8'd10, 8'd0, 8'd6}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h0000, 8'd5, 8'd10, 8'd200, 8'd0, 8'd1}, 1'b0, NO_WANT},
            '{'{ACT_HEADER, 16'h8000, 8'd5, 8'd240, 8'd250, 8'd128, 8'd128}, 1'b0, NO_WANT}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_settings(0);
        for (int i = 0; i < NUM_DIR; i++) begin
            drive_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            settle();
            apply_settings(phase);
            tx_no_idle = (phase == 3) || (phase == 5);
            rx_no_idle = (phase == 5);
            if (phase == 3) begin
                hold_off_req = 1'b1;
            end
            count = 0;
            while (count < PHASE_ITEMS) begin
                it = pick_item();
                drive_item(it, 1'b0, NO_WANT);
                if (it.action != ACT_NONE) begin
                    count++;
                end
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
